[rtl/sliding_median_of_seven_macros.svh]
// Assertion macros for the port-level checker.
// No dependencies.
`ifndef SLIDING_MEDIAN_OF_SEVEN_MACROS_SVH
`define SLIDING_MEDIAN_OF_SEVEN_MACROS_SVH
// implication under reset
`define SMED_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication under reset
`define SMED_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/smed_pkg.sv]
// Shared types and constants for the sliding median filter.
// No dependencies.
package smed_pkg;
  localparam int unsigned DefTaps = 7;
  localparam int unsigned SampleW = 32;

  // IEEE total order key: monotone unsigned compare
  function automatic logic [SampleW-1:0] order_key(input logic [SampleW-1:0] b);
    order_key = b[SampleW-1] ? ~b : (b ^ {1'b1, {(SampleW-1){1'b0}}});
  endfunction

  // control flag of one queued window beat towards the sorter
  typedef struct packed {
    logic last;
  } smed_ctl_t;
endpackage

[rtl/smed_front.sv]
// Front end: takes samples, keeps the window, emits one window beat per result.
// Depends on smed_pkg.
module smed_front import smed_pkg::*; #(
  parameter int unsigned TAPS = DefTaps
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SampleW-1:0]      in_sample,
  input  logic                    in_end_of_stream,
  output logic                    w_valid,
  input  logic                    w_stall,
  output logic [TAPS*SampleW-1:0] w_data,
  output smed_ctl_t               w_ctl
);
  localparam int unsigned Half = TAPS / 2;
  localparam int unsigned CntW = $clog2(TAPS + 1);
  localparam int unsigned FlW  = $clog2(Half + 1);

  logic [SampleW-1:0] win_r [TAPS];
  logic [SampleW-1:0] win_nxt [TAPS];
  logic [CntW-1:0]    fill_r, fill_nxt;
  // flush: remaining padded shifts, and how many of them are skipped before results are emitted
  logic [FlW-1:0]     flush_r, flush_nxt;
  logic [FlW-1:0]     skip_r, skip_nxt;
  logic               wv_r, wv_nxt, wl_r, wl_nxt;
  logic               adv;

  assign adv      = !wv_r || !w_stall;
  assign in_stall = (flush_r != '0) || !adv;
  assign w_valid  = wv_r;
  assign w_ctl.last = wl_r;

  always_comb begin
    logic [CntW-1:0] f1;
    logic [FlW-1:0]  rem;
    logic            em;
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    flush_nxt = flush_r;
    skip_nxt  = skip_r;
    wv_nxt    = wv_r && w_stall;
    wl_nxt    = wl_r;
    f1 = '0;
    rem = '0;
    em = 1'b0;
    if (adv) begin
      if (flush_r != '0) begin
        for (int i = 0; i < TAPS - 1; i++) win_nxt[i] = win_r[i + 1];
        rem = flush_r - 1'b1;
        flush_nxt = rem;
        if (skip_r != '0) begin
          skip_nxt = skip_r - 1'b1;
          wv_nxt = 1'b0;
        end else begin
          wv_nxt = 1'b1;
          wl_nxt = (rem == '0);
        end
      end else if (in_valid) begin
        if (fill_r == '0) begin
          for (int i = 0; i < TAPS; i++) win_nxt[i] = in_sample;
        end else begin
          for (int i = 0; i < TAPS - 1; i++) win_nxt[i] = win_r[i + 1];
          win_nxt[TAPS-1] = in_sample;
        end
        f1 = (fill_r < CntW'(TAPS)) ? fill_r + 1'b1 : fill_r;
        em = (f1 > CntW'(Half));
        if (in_end_of_stream) begin
          fill_nxt  = '0;
          flush_nxt = FlW'(Half);
          // padded shift k emits when f1 + k > Half
          skip_nxt  = em ? '0 : FlW'(CntW'(Half) - f1);
          wv_nxt    = em;
          wl_nxt    = 1'b0;
          if (!em) wv_nxt = 1'b0;
        end else begin
          fill_nxt = f1;
          wv_nxt   = em;
          wl_nxt   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      flush_r <= '0;
      skip_r  <= '0;
      wv_r    <= 1'b0;
      wl_r    <= 1'b0;
    end else begin
      fill_r  <= fill_nxt;
      flush_r <= flush_nxt;
      skip_r  <= skip_nxt;
      wv_r    <= wv_nxt;
      wl_r    <= wl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  for (genvar g = 0; g < TAPS; g++) begin : g_pack
    assign w_data[g*SampleW +: SampleW] = win_r[g];
  end
endmodule

[rtl/smed_fifo.sv]
// Short queue between front end and sorter.
// Depends on smed_pkg.
module smed_fifo import smed_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             i_valid,
  output logic             i_stall,
  input  logic [WIDTH-1:0] i_data,
  output logic             o_valid,
  input  logic             o_stall,
  output logic [WIDTH-1:0] o_data
);
  // two-entry queue, full throughput
  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             push, pop;

  assign i_stall = (cnt_r == 2'd2);
  assign o_valid = (cnt_r != 2'd0);
  assign o_data  = mem_r[rp_r];
  assign push    = i_valid && !i_stall;
  assign pop     = o_valid && !o_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= i_data;
  end
endmodule

[rtl/smed_back.sv]
// Back end: rank-select median of the window, pipelined in two stages.
// Depends on smed_pkg.
module smed_back import smed_pkg::*; #(
  parameter int unsigned TAPS = DefTaps
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    w_valid,
  output logic                    w_stall,
  input  logic [TAPS*SampleW-1:0] w_data,
  input  smed_ctl_t               w_ctl,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SampleW-1:0]      out_median,
  output logic                    out_final_res
);
  localparam int unsigned Half = TAPS / 2;

  // stage 1: pairwise compare matrix
  logic                 v1_r, v2_r;
  logic [TAPS*TAPS-1:0] lt_r;
  logic [TAPS*SampleW-1:0] d1_r;
  logic                 l1_r;
  logic [SampleW-1:0]   med_r;
  logic                 l2_r;
  logic                 adv1, adv2;
  logic [TAPS*TAPS-1:0] lt_nxt;
  logic [SampleW-1:0]   med_nxt;

  assign adv2 = !v2_r || !out_stall;
  assign adv1 = !v1_r || adv2;
  assign w_stall = !adv1;

  // element i precedes j in a stable order
  always_comb begin
    logic [SampleW-1:0] ki, kj;
    for (int i = 0; i < TAPS; i++) begin
      for (int j = 0; j < TAPS; j++) begin
        ki = order_key(w_data[i*SampleW +: SampleW]);
        kj = order_key(w_data[j*SampleW +: SampleW]);
        lt_nxt[i*TAPS+j] = (ki < kj) || ((ki == kj) && (i < j));
      end
    end
  end

  // stage 2: element with exactly Half predecessors
  always_comb begin
    logic [$clog2(TAPS+1)-1:0] rank;
    med_nxt = '0;
    for (int j = 0; j < TAPS; j++) begin
      rank = '0;
      for (int i = 0; i < TAPS; i++) rank = rank + lt_r[i*TAPS+j];
      if (rank == ($clog2(TAPS+1))'(Half)) med_nxt = d1_r[j*SampleW +: SampleW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= w_valid;
      if (adv2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      lt_r <= lt_nxt;
      d1_r <= w_data;
      l1_r <= w_ctl.last;
    end
    if (adv2) begin
      med_r <= med_nxt;
      l2_r  <= l1_r;
    end
  end

  assign out_valid     = v2_r;
  assign out_median    = med_r;
  assign out_final_res = l2_r;
endmodule

[rtl/sliding_median_of_seven.sv]
// Top level of the streaming seven-tap median filter.
// Depends on smed_pkg, smed_front, smed_fifo, smed_back.
//
//  channel | ports                                        | direction
//  in      | in_valid in_stall in_sample in_end_of_stream | samples in
//  out     | out_valid out_stall out_median out_final_res | medians out
//
// One sample per clock is taken while the output flows. The front end registers
// each window beat, the queue stores it, and the rank unit registers its compare
// matrix and then the median before the result is valid.
// A final sample is followed by Half padded flush shifts in the front end,
// during which in_stall is high.
// Reset is synchronous, active low, and clears all valid, count and pointer state.
// out_stall backs up through the queue to in_stall.
module sliding_median_of_seven import smed_pkg::*; #(
  parameter int unsigned TAPS = DefTaps
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [SampleW-1:0] in_sample,
  input  logic               in_end_of_stream,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SampleW-1:0] out_median,
  output logic               out_final_res
);
  localparam int unsigned QW = TAPS * SampleW + 1;

  logic                    fv, fs, bv, bs;
  logic [TAPS*SampleW-1:0] fd;
  smed_ctl_t               fc, bc;
  logic [QW-1:0]           qo;

  smed_front #(.TAPS(TAPS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_sample, .in_end_of_stream,
    .w_valid(fv), .w_stall(fs), .w_data(fd), .w_ctl(fc)
  );

  smed_fifo #(.WIDTH(QW)) u_fifo (
    .clk, .rst_n, .i_valid(fv), .i_stall(fs), .i_data({fc, fd}),
    .o_valid(bv), .o_stall(bs), .o_data(qo)
  );

  assign bc = qo[QW-1];

  smed_back #(.TAPS(TAPS)) u_back (
    .clk, .rst_n, .w_valid(bv), .w_stall(bs), .w_data(qo[QW-2:0]), .w_ctl(bc),
    .out_valid, .out_stall, .out_median, .out_final_res
  );
endmodule

[rtl/smed_checker.sv]
// Port-level checks for the median filter, bound to the top level.
// Depends on sliding_median_of_seven_macros.svh.
`include "sliding_median_of_seven_macros.svh"
module smed_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_median,
  input logic        out_final_res
);
  logic out_held;

  assign out_held = out_valid && out_stall;

  `SMED_ASSERT_NXT(a_hold, out_held, out_valid && $stable(out_median), "held beat moved")
  `SMED_ASSERT_NXT(a_final_hold, out_held, $stable(out_final_res), "held final flag moved")
  `SMED_ASSERT_IMP(a_rst_quiet, $past(!rst_n), !out_valid && !in_stall, "busy after reset")
  `SMED_ASSERT_NXT(a_in_hold, in_valid && in_stall, in_valid, "stalled sample dropped")
endmodule

bind sliding_median_of_seven smed_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_median, .out_final_res
);
